>>> design/assert_macros.svh
// shared assertion macros, clocked on aclk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// holds at every edge outside reset
`define CFSD_ASSERT(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("cfsd check failed");

// implication checked outside reset
`define CFSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cfsd check failed");

// checked at every edge, reset included
`define CFSD_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("cfsd reset check failed");

`endif

>>> design/cfsd_pkg.sv
`default_nettype none
package cfsd_pkg;

    localparam int UV_FRAC_BITS_DEF = 16;
    localparam int COORD_W          = 25;
    localparam int DIV_W            = 9;   // divisor 2d, at most 510
    localparam int MIP_MAX          = 14;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    // sideband carried alongside the quotient bits
    typedef struct packed {
        logic [2:0] face;
        logic [3:0] mip;
        logic       neg_u;
        logic       neg_v;
    } cfsd_side_t;

    // floor(16a/255) clamped: count thresholds ceil(255k/16) that a reaches
    function automatic logic [3:0] mip_of(input logic [7:0] a);
        logic [3:0] m;
        m = 4'd0;
        for (int k = 1; k <= MIP_MAX; k++) begin
            if (a >= 8'((255 * k + 15) >> 4)) begin
                m = 4'(k);
            end
        end
        return m;
    endfunction

endpackage
`default_nettype wire

>>> design/cfsd_decode.sv
`default_nettype none
module cfsd_decode #(
    parameter int UV_FRAC_BITS = cfsd_pkg::UV_FRAC_BITS_DEF
) (
    input  wire logic [31:0]                  word,
    output cfsd_pkg::cfsd_side_t              side,
    output logic [cfsd_pkg::DIV_W-1:0]        div,
    output logic [UV_FRAC_BITS+8:0]           num_u,
    output logic [UV_FRAC_BITS+8:0]           num_v
);
    logic signed [9:0] sx, sy, sz, pu, pv, su, sv;
    logic [7:0] ax, ay, az, d;
    logic [8:0] mag_u, mag_v;
    logic [2:0] face;

    always_comb begin
        sx = $signed({1'b0, word[23:16], 1'b0}) - 10'sd255;
        sy = $signed({1'b0, word[15:8], 1'b0}) - 10'sd255;
        sz = $signed({1'b0, word[7:0], 1'b0}) - 10'sd255;
        ax = sx[9] ? 8'(-sx) : sx[7:0];
        ay = sy[9] ? 8'(-sy) : sy[7:0];
        az = sz[9] ? 8'(-sz) : sz[7:0];

        // strict majors pick x or y, anything else lands on z
        if (ax > ay && ax > az) begin
            d = ax;
            if (!sx[9]) begin
                face = cfsd_pkg::FACE_POS_X; pu = -sz; pv = -sy;
            end else begin
                face = cfsd_pkg::FACE_NEG_X; pu = sz;  pv = -sy;
            end
        end else if (ay > ax && ay > az) begin
            d = ay;
            if (!sy[9]) begin
                face = cfsd_pkg::FACE_POS_Y; pu = sx; pv = sz;
            end else begin
                face = cfsd_pkg::FACE_NEG_Y; pu = sx; pv = -sz;
            end
        end else begin
            d = az;
            if (!sz[9]) begin
                face = cfsd_pkg::FACE_POS_Z; pu = sx;  pv = -sy;
            end else begin
                face = cfsd_pkg::FACE_NEG_Z; pu = -sx; pv = -sy;
            end
        end

        su    = $signed({2'b00, d}) + pu;
        sv    = $signed({2'b00, d}) + pv;
        mag_u = su[9] ? 9'(-su) : su[8:0];
        mag_v = sv[9] ? 9'(-sv) : sv[8:0];

        // |d+p| * 2^F + d, the +d gives round half away from zero
        num_u = {mag_u, UV_FRAC_BITS'(d)};
        num_v = {mag_v, UV_FRAC_BITS'(d)};
        div   = {d, 1'b0};

        side.face  = face;
        side.mip   = cfsd_pkg::mip_of(word[31:24]);
        side.neg_u = su[9];
        side.neg_v = sv[9];
    end
endmodule
`default_nettype wire

>>> design/cfsd_cell.sv
`default_nettype none
// one restoring division step for both coordinates
module cfsd_cell #(
    parameter int QW = cfsd_pkg::UV_FRAC_BITS_DEF + 8
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire cfsd_pkg::cfsd_side_t          in_side,
    input  wire logic [cfsd_pkg::DIV_W-1:0]    in_div,
    input  wire logic [cfsd_pkg::DIV_W-1:0]    in_rem_u,
    input  wire logic [cfsd_pkg::DIV_W-1:0]    in_rem_v,
    input  wire logic [QW-1:0]                 in_sr_u,
    input  wire logic [QW-1:0]                 in_sr_v,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output cfsd_pkg::cfsd_side_t               out_side,
    output logic [cfsd_pkg::DIV_W-1:0]         out_div,
    output logic [cfsd_pkg::DIV_W-1:0]         out_rem_u,
    output logic [cfsd_pkg::DIV_W-1:0]         out_rem_v,
    output logic [QW-1:0]                      out_sr_u,
    output logic [QW-1:0]                      out_sr_v
);
    localparam int TW = cfsd_pkg::DIV_W + 1;

    logic                         valid_reg;
    cfsd_pkg::cfsd_side_t         side_reg;
    logic [cfsd_pkg::DIV_W-1:0]   div_reg, rem_u_reg, rem_v_reg, rem_u_next, rem_v_next;
    logic [QW-1:0]                sr_u_reg, sr_v_reg, sr_u_next, sr_v_next;
    logic [TW-1:0]                t_u, t_v;
    logic                         ge_u, ge_v;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        t_u  = {in_rem_u, in_sr_u[QW-1]};
        t_v  = {in_rem_v, in_sr_v[QW-1]};
        ge_u = t_u >= {1'b0, in_div};
        ge_v = t_v >= {1'b0, in_div};
        rem_u_next = ge_u ? cfsd_pkg::DIV_W'(t_u - {1'b0, in_div}) : cfsd_pkg::DIV_W'(t_u);
        rem_v_next = ge_v ? cfsd_pkg::DIV_W'(t_v - {1'b0, in_div}) : cfsd_pkg::DIV_W'(t_v);
        // consumed numerator bit leaves the top, quotient bit enters the bottom
        sr_u_next = {in_sr_u[QW-2:0], ge_u};
        sr_v_next = {in_sr_v[QW-2:0], ge_v};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            side_reg  <= in_side;
            div_reg   <= in_div;
            rem_u_reg <= rem_u_next;
            rem_v_reg <= rem_v_next;
            sr_u_reg  <= sr_u_next;
            sr_v_reg  <= sr_v_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_div   = div_reg;
    assign out_rem_u = rem_u_reg;
    assign out_rem_v = rem_v_reg;
    assign out_sr_u  = sr_u_reg;
    assign out_sr_v  = sr_v_reg;
endmodule
`default_nettype wire

>>> design/cube_face_sample_decoder_unit.sv
`default_nettype none
// channel   direction  handshake          payload
// s_        in         s_valid / s_ready  s_encoded_sample
// m_        out        m_valid / m_ready  m_face, m_mip_level, m_u_coord, m_v_coord
//
// one item per cycle sustained while m_ready stays high; stages in order:
// (decode register, UV_FRAC_BITS + 8 division cells, output register)
// the row of division cells sets the latency: one quotient bit per cell
// reset: aresetn low clears every stage valid, payload registers are not reset
// stalls: each stage takes a new item when empty or when its successor moves,
// so bubbles close up and input stays open while a result waits at m_, until no stage is empty
// a zero word is accepted and dropped, it never enters the pipeline
module cube_face_sample_decoder_unit #(
    parameter int UV_FRAC_BITS = cfsd_pkg::UV_FRAC_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [31:0]                         s_encoded_sample,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [2:0]                               m_face,
    output logic [3:0]                               m_mip_level,
    output logic signed [cfsd_pkg::COORD_W-1:0]      m_u_coord,
    output logic signed [cfsd_pkg::COORD_W-1:0]      m_v_coord
);
    localparam int QW  = UV_FRAC_BITS + 8;   // quotient width, also cell count
    localparam int NW  = UV_FRAC_BITS + 9;   // numerator width
    localparam int CW  = cfsd_pkg::COORD_W;
    localparam int EW  = ((QW > CW) ? QW : CW) + 1;
    localparam int DW  = cfsd_pkg::DIV_W;

    // decode stage
    cfsd_pkg::cfsd_side_t dec_side;
    logic [DW-1:0]        dec_div;
    logic [NW-1:0]        dec_num_u, dec_num_v;

    cfsd_decode #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_decode (
        .word  (s_encoded_sample),
        .side  (dec_side),
        .div   (dec_div),
        .num_u (dec_num_u),
        .num_v (dec_num_v)
    );

    logic                 dv_reg;
    cfsd_pkg::cfsd_side_t dside_reg;
    logic [DW-1:0]        ddiv_reg;
    logic [NW-1:0]        dnum_u_reg, dnum_v_reg;

    // chain links: index 0 is the decode register, index QW the last cell
    logic                 ch_valid [QW+1];
    logic                 ch_ready [QW+1];
    cfsd_pkg::cfsd_side_t ch_side  [QW+1];
    logic [DW-1:0]        ch_div   [QW+1];
    logic [DW-1:0]        ch_rem_u [QW+1];
    logic [DW-1:0]        ch_rem_v [QW+1];
    logic [QW-1:0]        ch_sr_u  [QW+1];
    logic [QW-1:0]        ch_sr_v  [QW+1];

    assign s_ready = !dv_reg || ch_ready[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= 1'b0;
        end else if (s_ready) begin
            dv_reg <= s_valid && (s_encoded_sample != 32'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            dside_reg  <= dec_side;
            ddiv_reg   <= dec_div;
            dnum_u_reg <= dec_num_u;
            dnum_v_reg <= dec_num_v;
        end
    end

    // quotient is below 2^QW, so the top numerator bit is the starting remainder
    assign ch_valid[0] = dv_reg;
    assign ch_side[0]  = dside_reg;
    assign ch_div[0]   = ddiv_reg;
    assign ch_rem_u[0] = DW'(dnum_u_reg[NW-1]);
    assign ch_rem_v[0] = DW'(dnum_v_reg[NW-1]);
    assign ch_sr_u[0]  = dnum_u_reg[QW-1:0];
    assign ch_sr_v[0]  = dnum_v_reg[QW-1:0];

    for (genvar i = 0; i < QW; i++) begin : g_cell
        cfsd_cell #(.QW(QW)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[i]),
            .in_ready  (ch_ready[i]),
            .in_side   (ch_side[i]),
            .in_div    (ch_div[i]),
            .in_rem_u  (ch_rem_u[i]),
            .in_rem_v  (ch_rem_v[i]),
            .in_sr_u   (ch_sr_u[i]),
            .in_sr_v   (ch_sr_v[i]),
            .out_valid (ch_valid[i+1]),
            .out_ready (ch_ready[i+1]),
            .out_side  (ch_side[i+1]),
            .out_div   (ch_div[i+1]),
            .out_rem_u (ch_rem_u[i+1]),
            .out_rem_v (ch_rem_v[i+1]),
            .out_sr_u  (ch_sr_u[i+1]),
            .out_sr_v  (ch_sr_v[i+1])
        );
    end

    // sign and saturate the quotients
    logic [EW-1:0]    q_u, q_v, lim_u, lim_v, sat_u, sat_v;
    logic [CW-1:0]    res_u, res_v;
    cfsd_pkg::cfsd_side_t last_side;

    always_comb begin
        last_side = ch_side[QW];
        q_u   = EW'(ch_sr_u[QW]);
        q_v   = EW'(ch_sr_v[QW]);
        // negative side reaches -2^(CW-1), positive side 2^(CW-1)-1
        lim_u = last_side.neg_u ? (EW'(1) << (CW - 1)) : ((EW'(1) << (CW - 1)) - EW'(1));
        lim_v = last_side.neg_v ? (EW'(1) << (CW - 1)) : ((EW'(1) << (CW - 1)) - EW'(1));
        sat_u = (q_u > lim_u) ? lim_u : q_u;
        sat_v = (q_v > lim_v) ? lim_v : q_v;
        res_u = last_side.neg_u ? CW'(-sat_u) : CW'(sat_u);
        res_v = last_side.neg_v ? CW'(-sat_v) : CW'(sat_v);
    end

    // output register
    logic          ov_reg;
    logic [2:0]    face_reg;
    logic [3:0]    mip_reg;
    logic [CW-1:0] u_reg, v_reg;

    assign ch_ready[QW] = !ov_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg <= 1'b0;
        end else if (ch_ready[QW]) begin
            ov_reg <= ch_valid[QW];
        end
    end

    always_ff @(posedge aclk) begin
        if (ch_ready[QW] && ch_valid[QW]) begin
            face_reg <= last_side.face;
            mip_reg  <= last_side.mip;
            u_reg    <= res_u;
            v_reg    <= res_v;
        end
    end

    assign m_valid     = ov_reg;
    assign m_face      = face_reg;
    assign m_mip_level = mip_reg;
    assign m_u_coord   = $signed(u_reg);
    assign m_v_coord   = $signed(v_reg);
endmodule
`default_nettype wire

>>> design/cfsd_checker.sv
`default_nettype none
`include "assert_macros.svh"
module cfsd_checker #(
    parameter int UV_FRAC_BITS = cfsd_pkg::UV_FRAC_BITS_DEF
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic [31:0]                       s_encoded_sample,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic [2:0]                        m_face,
    input wire logic [3:0]                        m_mip_level,
    input wire logic signed [cfsd_pkg::COORD_W-1:0] m_u_coord,
    input wire logic signed [cfsd_pkg::COORD_W-1:0] m_v_coord
);
    localparam longint ONE_FX = longint'(1) << UV_FRAC_BITS;

    logic unused_in;
    assign unused_in = s_valid ^ s_ready ^ (^s_encoded_sample);

    // no result straight out of reset
    `CFSD_ASSERT_RST(a_reset_quiet, !aresetn |=> !m_valid)

    // face and mip stay in their ranges
    `CFSD_ASSERT_IMP(a_face_range, m_valid,
        m_face <= cfsd_pkg::FACE_NEG_Z && m_mip_level <= 4'(cfsd_pkg::MIP_MAX))

    // on x and y faces the minor components never exceed the major one
    `CFSD_ASSERT_IMP(a_xy_in_unit, m_valid && m_face <= cfsd_pkg::FACE_NEG_Y,
        longint'(m_u_coord) >= 0 && longint'(m_u_coord) <= ONE_FX &&
        longint'(m_v_coord) >= 0 && longint'(m_v_coord) <= ONE_FX)

    // a waiting result holds
    `CFSD_ASSERT_IMP(a_hold, m_valid && !m_ready,
        ##1 (m_valid && $stable(m_face) && $stable(m_u_coord) && $stable(m_v_coord)))
endmodule

bind cube_face_sample_decoder_unit cfsd_checker #(.UV_FRAC_BITS(UV_FRAC_BITS)) u_cfsd_checker (.*);
`default_nettype wire

>>> dv/tb_cube_face_sample_decoder_unit.sv
`default_nettype none
module tb_cube_face_sample_decoder_unit;

    localparam int CLK_PERIOD   = 20;
    localparam int FRAC         = cfsd_pkg::UV_FRAC_BITS_DEF;
    // pipeline depth from the port-list notes, plus margin for the drain
    localparam int DRAIN_CYCLES = FRAC + 30;
    // slowest run: ~825 items, with sender gaps between bursts and receiver stalls,
    // taken many times over
    localparam int LIMIT_CYCLES = 300000;
    localparam int N_RANDOM     = 800;

    localparam longint COORD_HI = (longint'(1) <<< (cfsd_pkg::COORD_W - 1)) - 1;
    localparam longint COORD_LO = -(longint'(1) <<< (cfsd_pkg::COORD_W - 1));

    // receiver behaviour, changed from phase to phase
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_CHOPPY,
        RX_SLUGGISH
    } rx_mode_t;

    typedef struct {
        logic [2:0]                          face;
        logic [3:0]                          mip;
        logic signed [cfsd_pkg::COORD_W-1:0] u;
        logic signed [cfsd_pkg::COORD_W-1:0] v;
    } face_sample_t;

    logic                                aclk             = 1'b0;
    logic                                aresetn          = 1'b0;
    logic                                s_valid          = 1'b0;
    logic                                s_ready;
    logic [31:0]                         s_encoded_sample = '0;
    logic                                m_valid;
    logic                                m_ready          = 1'b0;
    logic [2:0]                          m_face;
    logic [3:0]                          m_mip_level;
    logic signed [cfsd_pkg::COORD_W-1:0] m_u_coord;
    logic signed [cfsd_pkg::COORD_W-1:0] m_v_coord;

    // words waiting to be sent, and decoded samples waiting to come out
    logic [31:0]   pending_words[$];
    face_sample_t  expected_samples[$];

    int n_words_total = 0;
    int n_accepted    = 0;
    int n_dropped     = 0;
    int n_checked     = 0;
    int n_errors      = 0;
    int face_hits[6]  = '{default: 0};

    // sender burst/gap bookkeeping
    int burst_left = 0;
    int idle_left  = 0;

    // receiver stall pattern
    rx_mode_t rx_mode  = RX_STEADY;
    int       rx_phase = 0;

    face_sample_t drv_res;
    face_sample_t mon_res;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    cube_face_sample_decoder_unit #(
        .UV_FRAC_BITS (FRAC)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_encoded_sample (s_encoded_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_face           (m_face),
        .m_mip_level      (m_mip_level),
        .m_u_coord        (m_u_coord),
        .m_v_coord        (m_v_coord)
    );

    // --------------------------------------------------------------------
    // prediction
    // --------------------------------------------------------------------

    // byte c mapped to the odd component 2c - 255, never zero
    function automatic int to_component(input logic [7:0] c);
        return 2 * int'(c) - 255;
    endfunction

    // (d + p) / (2d) as fixed point, nearest step, halves away from zero,
    // saturated to the coordinate width
    function automatic logic signed [cfsd_pkg::COORD_W-1:0] face_ratio(input int d,
                                                                      input int p);
        longint num;
        longint mag;
        longint q;
        num = longint'(d + p) * (longint'(1) <<< FRAC);
        mag = (num < 0) ? -num : num;
        q   = (mag + longint'(d)) / (2 * longint'(d));
        if (num < 0) begin
            q = -q;
        end
        if (q > COORD_HI) begin
            q = COORD_HI;
        end
        if (q < COORD_LO) begin
            q = COORD_LO;
        end
        return q[cfsd_pkg::COORD_W-1:0];
    endfunction

    // returns 0 for a word that is dropped, else fills in the decoded sample
    function automatic bit decode_sample(input logic [31:0] w, output face_sample_t r);
        int sx, sy, sz;
        int ax, ay, az;
        int d, pu, pv;
        int lod_scaled;
        r = '{default: '0};
        if (w == 32'd0) begin
            return 1'b0;
        end
        sx = to_component(w[23:16]);
        sy = to_component(w[15:8]);
        sz = to_component(w[7:0]);
        ax = (sx < 0) ? -sx : sx;
        ay = (sy < 0) ? -sy : sy;
        az = (sz < 0) ? -sz : sz;

        lod_scaled = (16 * int'(w[31:24])) / 255;
        r.mip = (lod_scaled > cfsd_pkg::MIP_MAX) ? 4'(cfsd_pkg::MIP_MAX) : 4'(lod_scaled);

        // strict majority picks x or y, anything tied falls through to z
        if (ax > ay && ax > az) begin
            d = ax;
            if (sx > 0) begin
                r.face = cfsd_pkg::FACE_POS_X; pu = -sz; pv = -sy;
            end else begin
                r.face = cfsd_pkg::FACE_NEG_X; pu = sz;  pv = -sy;
            end
        end else if (ay > ax && ay > az) begin
            d = ay;
            if (sy > 0) begin
                r.face = cfsd_pkg::FACE_POS_Y; pu = sx; pv = sz;
            end else begin
                r.face = cfsd_pkg::FACE_NEG_Y; pu = sx; pv = -sz;
            end
        end else begin
            d = az;
            if (sz > 0) begin
                r.face = cfsd_pkg::FACE_POS_Z; pu = sx;  pv = -sy;
            end else begin
                r.face = cfsd_pkg::FACE_NEG_Z; pu = -sx; pv = -sy;
            end
        end
        r.u = face_ratio(d, pu);
        r.v = face_ratio(d, pv);
        return 1'b1;
    endfunction

    // --------------------------------------------------------------------
    // stimulus generation
    // --------------------------------------------------------------------

    // colour byte: often a boundary value (components +-1, +-253, +-255)
    function automatic logic [7:0] colour_byte();
        logic [7:0] edges[6];
        edges = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'hFE, 8'hFF};
        if ($urandom_range(0, 3) == 0) begin
            return edges[$urandom_range(0, 5)];
        end
        return 8'($urandom_range(0, 255));
    endfunction

    // random word biased towards components of equal magnitude: an inverted byte has
    // the same magnitude with the opposite sign
    function automatic logic [31:0] random_word();
        logic [7:0] a, r, g, b;
        if ($urandom_range(0, 49) == 0) begin
            return 32'd0;
        end
        a = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        r = colour_byte();
        g = colour_byte();
        b = colour_byte();
        case ($urandom_range(0, 7))
            0: g = $urandom_range(0, 1) ? r : ~r;
            1: b = $urandom_range(0, 1) ? r : ~r;
            2: b = $urandom_range(0, 1) ? g : ~g;
            3: begin
                g = $urandom_range(0, 1) ? r : ~r;
                b = $urandom_range(0, 1) ? r : ~r;
            end
            default: ;
        endcase
        return {a, r, g, b};
    endfunction

    // append a word to the send queue
    function automatic void queue_word(input logic [31:0] w);
        pending_words.insert(pending_words.size(), w);
    endfunction

    // --------------------------------------------------------------------
    // driver: bursts of items with random gaps, fed from pending_words
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            // an item moved at this edge: predict what it should produce
            if (s_valid && s_ready) begin
                n_accepted++;
                if (decode_sample(s_encoded_sample, drv_res)) begin
                    expected_samples.insert(expected_samples.size(), drv_res);
                end else begin
                    n_dropped++;
                end
            end
            // only touch the channel when nothing is left hanging on it
            if (!s_valid || s_ready) begin
                if (idle_left != 0) begin
                    idle_left <= idle_left - 1;
                    s_valid   <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    s_valid          <= 1'b1;
                    s_encoded_sample <= pending_words.pop_front();
                    if (burst_left <= 1) begin
                        // end of burst: pick the next one and the gap before it
                        burst_left <= $urandom_range(1, 40);
                        idle_left  <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // receiver: stall pattern that switches mode at the end of each random-length phase
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        if (rx_phase == 0) begin
            rx_mode  <= rx_mode_t'($urandom_range(0, 2));
            rx_phase <= $urandom_range(20, 200);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        case (rx_mode)
            RX_STEADY:   m_ready <= 1'b1;
            RX_CHOPPY:   m_ready <= ($urandom_range(0, 2) != 0);
            RX_SLUGGISH: m_ready <= ($urandom_range(0, 3) == 0);
            default:     m_ready <= 1'b1;
        endcase
    end

    // --------------------------------------------------------------------
    // monitor: each result against the oldest prediction
    // --------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_samples.size() == 0) begin
                $error("result with nothing expected: face %0d mip %0d u %0d v %0d",
                       m_face, m_mip_level, m_u_coord, m_v_coord);
                n_errors++;
            end else begin
                mon_res = expected_samples.pop_front();
                n_checked++;
                if (mon_res.face <= cfsd_pkg::FACE_NEG_Z) begin
                    face_hits[mon_res.face]++;
                end
                if (m_face !== mon_res.face) begin
                    $error("face: expected %0d, got %0d", mon_res.face, m_face);
                    n_errors++;
                end
                if (m_mip_level !== mon_res.mip) begin
                    $error("mip_level: expected %0d, got %0d", mon_res.mip, m_mip_level);
                    n_errors++;
                end
                if (m_u_coord !== mon_res.u) begin
                    $error("u_coord: expected %0d, got %0d", mon_res.u, m_u_coord);
                    n_errors++;
                end
                if (m_v_coord !== mon_res.v) begin
                    $error("v_coord: expected %0d, got %0d", mon_res.v, m_v_coord);
                    n_errors++;
                end
            end
        end
    end

    // --------------------------------------------------------------------
    // sequence: reset, directed words, random words, drain, verdict
    // --------------------------------------------------------------------
    initial begin
        // zero word, dropped
        queue_word(32'h0000_0000);
        // lod only with zero colour: all components -255, lands on -z
        queue_word(32'h0100_0000);
        queue_word(32'h8000_0000);
        // all components +1: three-way tie at the smallest magnitude, mip clamped
        queue_word(32'hFF80_8080);
        // one clean word per face, lod around the mip thresholds
        queue_word(32'hF0FF_8080);
        queue_word(32'hEF00_8080);
        queue_word(32'h1080_FF80);
        queue_word(32'h0F80_0080);
        queue_word(32'h807F_7FFF);
        queue_word(32'h4080_8000);
        // x/y tie over a tiny z: u and v at their extremes, well outside [0,1]
        queue_word(32'h00FF_FF80);
        queue_word(32'h0000_FF7F);
        queue_word(32'hFFFE_0180);
        // full-scale ties
        queue_word(32'hFFFF_FFFF);
        queue_word(32'h00FF_0000);
        queue_word(32'h00FF_80FF);
        queue_word(32'h0080_FFFF);
        // smallest nonzero word, ratio just above one
        queue_word(32'h0000_0001);
        // components of magnitude one: all -1, then mixed signs
        queue_word(32'h2A7F_7F7F);
        queue_word(32'h5580_7F80);
        // near ties, strict majority by a single step, and one exact x/y tie
        queue_word(32'h00FF_0102);
        queue_word(32'h0001_0203);
        queue_word(32'h7F01_FE80);
        queue_word(32'h1102_FF01);

        for (int i = 0; i < N_RANDOM; i++) begin
            queue_word(random_word());
        end
        n_words_total = pending_words.size();

        // reset held low from the start, released on an edge
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // every word taken by the block
        do @(posedge aclk); while (n_accepted != n_words_total);
        // every prediction met
        do @(posedge aclk); while (expected_samples.size() != 0);
        // let any stray result surface before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d words sent, %0d zero words dropped, %0d results compared",
                 n_accepted, n_dropped, n_checked);
        $display("faces +x %0d  -x %0d  +y %0d  -y %0d  +z %0d  -z %0d",
                 face_hits[0], face_hits[1], face_hits[2],
                 face_hits[3], face_hits[4], face_hits[5]);
        if (n_errors == 0 && expected_samples.size() == 0) begin
            $display("tb_cube_face_sample_decoder_unit: clean");
        end else begin
            $display("tb_cube_face_sample_decoder_unit: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #(longint'(LIMIT_CYCLES) * CLK_PERIOD);
        $display("timeout with %0d of %0d words sent, %0d results pending",
                 n_accepted, n_words_total, expected_samples.size());
        $display("tb_cube_face_sample_decoder_unit: errors");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
+incdir+design
design/cfsd_pkg.sv
design/cfsd_decode.sv
design/cfsd_cell.sv
design/cube_face_sample_decoder_unit.sv
design/cfsd_checker.sv
dv/tb_cube_face_sample_decoder_unit.sv
